[sv/fbpa_pkg.sv]
// Package for the fixed block pool allocator: widths, status and register
// codes, FSM states and the structs passed between the submodules.
// No dependencies.
`default_nettype none

package fbpa_pkg;

	// Pool geometry
	localparam int MAX_BLOCKS = 1024;
	localparam int LINK_BYTES = 8;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);     // block index
	localparam int DEPTH_W    = $clog2(MAX_BLOCKS + 1); // stack depth, fresh index

	// Field widths
	localparam int RAW_W    = 17;
	localparam int ALIGN_W  = 4;
	localparam int CNT_W    = 11;
	localparam int REQ_W    = 17;
	localparam int OFF_W    = 26;
	localparam int LIVE_W   = 11;
	localparam int STATUS_W = 3;
	localparam int SIZE_W   = 18;                // effective size, up to 2^17
	localparam int LIMIT_W  = SIZE_W + CNT_W;    // size * count
	localparam int PROD_W   = SIZE_W + IDX_W;    // index * size
	localparam int DIV_CNT_W = $clog2(IDX_W + 1);

	// Stream and register port widths
	localparam int S_TDATA_W = 48;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 48;
	localparam int APB_DW    = 32;
	localparam int APB_AW    = 4;

	// Reset values of the registers
	localparam logic [RAW_W-1:0]   RAW_RST   = RAW_W'(64);
	localparam logic [ALIGN_W-1:0] ALIGN_RST = ALIGN_W'(3);
	localparam logic [CNT_W-1:0]   CNT_RST   = CNT_W'(1024);
	localparam logic [SIZE_W-1:0]  SIZE_RST  = SIZE_W'(64);

	localparam logic [LIVE_W-1:0]  LIVE_MAX  = {LIVE_W{1'b1}};

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_ALLOCATED  = 3'd0,
		STS_RELEASED   = 3'd1,
		STS_EXHAUSTED  = 3'd2,
		STS_TOO_LARGE  = 3'd3,
		STS_NULL       = 3'd4,
		STS_OUTSIDE    = 3'd5,
		STS_MISALIGNED = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		REG_RAW_BYTES = 2'd0,
		REG_ALIGN     = 2'd1,
		REG_COUNT     = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_POP,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

	// Derived pool configuration
	typedef struct packed {
		logic [SIZE_W-1:0] size;   // effective block size in bytes
		logic [CNT_W-1:0]  count;  // usable block count
	} cfg_t;

	// Divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Decision taken in the check state
	typedef struct packed {
		logic    reject;
		logic    pop;
		logic    fresh;
		logic    divide;
		status_t code;
	} chk_t;

endpackage

`default_nettype wire

[sv/fbpa_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module fbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[sv/fbpa_cfg.sv]
// Register port of the pool allocator: holds the three registers and derives
// the effective block size and usable block count. Depends on fbpa_pkg.
`default_nettype none

module fbpa_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [fbpa_pkg::APB_AW-1:0]   paddr,
	input  wire logic [fbpa_pkg::APB_DW-1:0]   pwdata,
	output      logic [fbpa_pkg::APB_DW-1:0]   prdata,
	output      logic                          pready,
	output      fbpa_pkg::cfg_t                cfg
);

	logic [fbpa_pkg::RAW_W-1:0]   raw_q;
	logic [fbpa_pkg::ALIGN_W-1:0] align_q;
	logic [fbpa_pkg::CNT_W-1:0]   count_q;
	fbpa_pkg::cfg_t               cfg_q;
	fbpa_pkg::reg_idx_t           sel;
	logic                         wr;
	logic [fbpa_pkg::RAW_W-1:0]   link_min;
	logic [fbpa_pkg::SIZE_W-1:0]  amask;
	logic [fbpa_pkg::SIZE_W-1:0]  rounded;
	logic [fbpa_pkg::CNT_W-1:0]   usable;

	assign pready = 1'b1;
	assign sel    = fbpa_pkg::reg_idx_t'(paddr[3:2]);
	assign wr     = psel && penable && pwrite;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q   <= fbpa_pkg::RAW_RST;
			align_q <= fbpa_pkg::ALIGN_RST;
			count_q <= fbpa_pkg::CNT_RST;
		end else if (wr) begin
			unique case (sel)
				fbpa_pkg::REG_RAW_BYTES: raw_q   <= pwdata[fbpa_pkg::RAW_W-1:0];
				fbpa_pkg::REG_ALIGN:     align_q <= pwdata[fbpa_pkg::ALIGN_W-1:0];
				fbpa_pkg::REG_COUNT:     count_q <= pwdata[fbpa_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		unique case (sel)
			fbpa_pkg::REG_RAW_BYTES: prdata = fbpa_pkg::APB_DW'(raw_q);
			fbpa_pkg::REG_ALIGN:     prdata = fbpa_pkg::APB_DW'(align_q);
			fbpa_pkg::REG_COUNT:     prdata = fbpa_pkg::APB_DW'(count_q);
			default:                 prdata = '0;
		endcase
	end

	// Effective size: at least one link, rounded up to the alignment
	always_comb begin
		link_min = (raw_q < fbpa_pkg::RAW_W'(fbpa_pkg::LINK_BYTES))
			? fbpa_pkg::RAW_W'(fbpa_pkg::LINK_BYTES) : raw_q;
		amask    = (fbpa_pkg::SIZE_W'(1) << align_q) - fbpa_pkg::SIZE_W'(1);
		rounded  = (fbpa_pkg::SIZE_W'(link_min) + amask) & ~amask;
		usable   = (count_q > fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS))
			? fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS) : count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.size  <= fbpa_pkg::SIZE_RST;
			cfg_q.count <= fbpa_pkg::CNT_RST;
		end else begin
			cfg_q.size  <= rounded;
			cfg_q.count <= usable;
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[sv/fbpa_div.sv]
// Restoring divider, one quotient bit per cycle, for offset / block size.
// The caller guarantees the quotient fits IDX_W bits. Depends on fbpa_pkg.
`default_nettype none

module fbpa_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [fbpa_pkg::OFF_W-1:0]    dividend,
	input  wire logic [fbpa_pkg::SIZE_W-1:0]   divisor,
	output      fbpa_pkg::div_stat_t           stat,
	output      logic [fbpa_pkg::IDX_W-1:0]    quot,
	output      logic                          rem_zero
);

	logic [fbpa_pkg::SIZE_W-1:0]    rem_q;
	logic [fbpa_pkg::IDX_W-1:0]     shf_q;   // dividend low bits in, quotient bits out
	logic [fbpa_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           done_q;
	logic [fbpa_pkg::SIZE_W:0]      trial;
	logic [fbpa_pkg::SIZE_W:0]      diff;
	logic                           ge;

	assign trial = {rem_q, shf_q[fbpa_pkg::IDX_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = trial >= {1'b0, divisor};

	// Step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == fbpa_pkg::DIV_CNT_W'(1));
			if (start) begin
				cnt_q <= fbpa_pkg::DIV_CNT_W'(fbpa_pkg::IDX_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - fbpa_pkg::DIV_CNT_W'(1);
			end
		end
	end

	// Partial remainder; high dividend bits are already below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= fbpa_pkg::SIZE_W'(dividend[fbpa_pkg::OFF_W-1:fbpa_pkg::IDX_W]);
			shf_q <= dividend[fbpa_pkg::IDX_W-1:0];
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[fbpa_pkg::SIZE_W-1:0] : trial[fbpa_pkg::SIZE_W-1:0];
			shf_q <= {shf_q[fbpa_pkg::IDX_W-2:0], ge};
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign quot      = shf_q;
	assign rem_zero  = (rem_q == '0);

endmodule

`default_nettype wire

[sv/fixed_block_pool_allocator.sv]
// Channel  | Dir | Handshake                 | Payload
// s_axis   | in  | s_axis_tvalid/tready      | tdata: request_bytes, release_offset;
//          |     |                           | tuser: op, release_null
// m_axis   | out | m_axis_tvalid/tready      | tdata: block_index, block_offset, live_blocks;
//          |     |                           | tuser: status
// apb      | in  | psel/penable/pwrite/pready| 3 registers at 0x0, 0x4, 0x8
//
// One item at a time. The result register loads from the output state, reached from the
// check state directly for a rejection (too large, exhausted, null, outside), via the
// multiply state for an allocate of a fresh index, via the free-stack RAM read and
// multiply for a stack pop, and via the 10-step offset / size divider for a release. The
// next word is taken the cycle after the load. Free stack lives in a 1024 x 10 RAM; no
// clearing pass, only entries below the stack depth are read. The result register frees
// the input side: a new word is taken while the previous result waits on m_axis_tready.
// Depends on fbpa_pkg, fbpa_cfg, fbpa_div, fbpa_ram.
`default_nettype none

module fixed_block_pool_allocator (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Register port
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [fbpa_pkg::APB_AW-1:0]       paddr,
	input  wire logic [fbpa_pkg::APB_DW-1:0]       pwdata,
	output      logic [fbpa_pkg::APB_DW-1:0]       prdata,
	output      logic                              pready,
	// Request stream
	input  wire logic                              s_axis_tvalid,
	output      logic                              s_axis_tready,
	input  wire logic [fbpa_pkg::S_TDATA_W-1:0]    s_axis_tdata, // request_bytes, release_offset
	input  wire logic [fbpa_pkg::S_TUSER_W-1:0]    s_axis_tuser, // op, release_null
	// Result stream
	output      logic                              m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output      logic [fbpa_pkg::M_TDATA_W-1:0]    m_axis_tdata, // block_index, block_offset, live_blocks
	output      logic [fbpa_pkg::STATUS_W-1:0]     m_axis_tuser  // status
);

	fbpa_pkg::cfg_t      cfg;
	fbpa_pkg::div_stat_t div_stat;
	fbpa_pkg::state_t    state_q, state_d;
	fbpa_pkg::chk_t      chk;

	// Captured request
	fbpa_pkg::op_t                  op_q;
	logic [fbpa_pkg::REQ_W-1:0]     req_q;
	logic                           null_q;
	logic [fbpa_pkg::OFF_W-1:0]     off_q;

	// Pool state
	logic [fbpa_pkg::DEPTH_W-1:0]   depth_q;
	logic [fbpa_pkg::DEPTH_W-1:0]   fresh_q;
	logic [fbpa_pkg::LIVE_W-1:0]    live_q;

	// Result being built
	fbpa_pkg::status_t              res_status_q;
	logic [fbpa_pkg::IDX_W-1:0]     res_idx_q;
	logic [fbpa_pkg::OFF_W-1:0]     res_boff_q;

	// Output register
	logic                           m_valid_q;
	fbpa_pkg::status_t              m_status_q;
	logic [fbpa_pkg::IDX_W-1:0]     m_idx_q;
	logic [fbpa_pkg::OFF_W-1:0]     m_boff_q;
	logic [fbpa_pkg::LIVE_W-1:0]    m_live_q;

	logic                           ram_re, ram_we, div_start, out_load;
	logic [fbpa_pkg::IDX_W-1:0]     ram_rdata;
	logic [fbpa_pkg::DEPTH_W-1:0]   depth_m1;
	logic [fbpa_pkg::IDX_W-1:0]     div_quot;
	logic                           div_rem_zero;
	logic [fbpa_pkg::LIMIT_W-1:0]   limit;
	logic [fbpa_pkg::PROD_W-1:0]    prod;
	logic                           too_big, outside, stack_full;

	fbpa_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fbpa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (off_q),
		.divisor  (cfg.size),
		.stat     (div_stat),
		.quot     (div_quot),
		.rem_zero (div_rem_zero)
	);

	// Free stack; push and pop never overlap since items run one at a time
	fbpa_ram #(
		.WIDTH (fbpa_pkg::IDX_W),
		.DEPTH (fbpa_pkg::MAX_BLOCKS)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (depth_q[fbpa_pkg::IDX_W-1:0]),
		.wdata (div_quot),
		.re    (ram_re),
		.raddr (depth_m1[fbpa_pkg::IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	assign depth_m1   = depth_q - fbpa_pkg::DEPTH_W'(1);
	assign stack_full = (depth_q == fbpa_pkg::DEPTH_W'(fbpa_pkg::MAX_BLOCKS));
	assign too_big    = {1'b0, req_q} > cfg.size;
	assign limit      = fbpa_pkg::LIMIT_W'(cfg.size) * fbpa_pkg::LIMIT_W'(cfg.count);
	assign outside    = fbpa_pkg::LIMIT_W'(off_q) >= limit;
	assign prod       = fbpa_pkg::PROD_W'(res_idx_q) * fbpa_pkg::PROD_W'(cfg.size);

	// Request checks, in the order the status codes take priority
	always_comb begin
		chk = '{reject: 1'b0, pop: 1'b0, fresh: 1'b0, divide: 1'b0,
			code: fbpa_pkg::STS_ALLOCATED};
		if (op_q == fbpa_pkg::OP_ALLOC) begin
			priority if (too_big) begin
				chk.reject = 1'b1;
				chk.code   = fbpa_pkg::STS_TOO_LARGE;
			end else if (depth_q != '0) begin
				chk.pop = 1'b1;
			end else if (fresh_q < fbpa_pkg::DEPTH_W'(cfg.count)) begin
				chk.fresh = 1'b1;
			end else begin
				chk.reject = 1'b1;
				chk.code   = fbpa_pkg::STS_EXHAUSTED;
			end
		end else begin
			priority if (null_q) begin
				chk.reject = 1'b1;
				chk.code   = fbpa_pkg::STS_NULL;
			end else if (outside) begin
				chk.reject = 1'b1;
				chk.code   = fbpa_pkg::STS_OUTSIDE;
			end else begin
				chk.divide = 1'b1;
			end
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbpa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and strobes
	always_comb begin
		state_d   = state_q;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			fbpa_pkg::ST_IDLE: begin
				if (s_axis_tvalid) state_d = fbpa_pkg::ST_CHECK;
			end
			fbpa_pkg::ST_CHECK: begin
				priority if (chk.reject) begin
					state_d = fbpa_pkg::ST_OUT;
				end else if (chk.pop) begin
					ram_re  = 1'b1;
					state_d = fbpa_pkg::ST_POP;
				end else if (chk.fresh) begin
					state_d = fbpa_pkg::ST_MUL;
				end else begin
					div_start = 1'b1;
					state_d   = fbpa_pkg::ST_DIV;
				end
			end
			fbpa_pkg::ST_POP: state_d = fbpa_pkg::ST_MUL;
			fbpa_pkg::ST_MUL: state_d = fbpa_pkg::ST_OUT;
			fbpa_pkg::ST_DIV: begin
				if (div_stat.done) begin
					ram_we  = div_rem_zero && !stack_full;
					state_d = fbpa_pkg::ST_OUT;
				end
			end
			fbpa_pkg::ST_OUT: begin
				if (!m_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = fbpa_pkg::ST_IDLE;
				end
			end
			default: state_d = fbpa_pkg::ST_IDLE;
		endcase
	end

	assign s_axis_tready = (state_q == fbpa_pkg::ST_IDLE);

	// Input capture
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_q   <= fbpa_pkg::op_t'(s_axis_tuser[0]);
			null_q <= s_axis_tuser[1];
			req_q  <= s_axis_tdata[fbpa_pkg::REQ_W-1:0];
			off_q  <= s_axis_tdata[fbpa_pkg::REQ_W+fbpa_pkg::OFF_W-1:fbpa_pkg::REQ_W];
		end
	end

	// Stack depth, fresh index and live count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			fresh_q <= '0;
			live_q  <= '0;
		end else begin
			if (state_q == fbpa_pkg::ST_CHECK && chk.pop) begin
				depth_q <= depth_m1;
			end
			if (state_q == fbpa_pkg::ST_CHECK && chk.fresh) begin
				fresh_q <= fresh_q + fbpa_pkg::DEPTH_W'(1);
			end
			if (state_q == fbpa_pkg::ST_MUL && live_q != fbpa_pkg::LIVE_MAX) begin
				live_q <= live_q + fbpa_pkg::LIVE_W'(1);
			end
			if (state_q == fbpa_pkg::ST_DIV && div_stat.done && div_rem_zero) begin
				if (!stack_full) depth_q <= depth_q + fbpa_pkg::DEPTH_W'(1);
				if (live_q != '0) live_q <= live_q - fbpa_pkg::LIVE_W'(1);
			end
		end
	end

	// Result fields
	always_ff @(posedge clk) begin
		unique case (state_q)
			fbpa_pkg::ST_CHECK: begin
				if (chk.reject) begin
					res_status_q <= chk.code;
					res_idx_q    <= '0;
					res_boff_q   <= '0;
				end else if (chk.fresh) begin
					res_idx_q <= fresh_q[fbpa_pkg::IDX_W-1:0];
				end
			end
			fbpa_pkg::ST_POP: res_idx_q <= ram_rdata;
			fbpa_pkg::ST_MUL: begin
				res_status_q <= fbpa_pkg::STS_ALLOCATED;
				res_boff_q   <= prod[fbpa_pkg::OFF_W-1:0];
			end
			fbpa_pkg::ST_DIV: begin
				if (div_stat.done) begin
					if (div_rem_zero) begin
						res_status_q <= fbpa_pkg::STS_RELEASED;
						res_idx_q    <= div_quot;
						res_boff_q   <= off_q;
					end else begin
						res_status_q <= fbpa_pkg::STS_MISALIGNED;
						res_idx_q    <= '0;
						res_boff_q   <= '0;
					end
				end
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_status_q <= res_status_q;
			m_idx_q    <= res_idx_q;
			m_boff_q   <= res_boff_q;
			m_live_q   <= live_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, m_live_q, m_boff_q, m_idx_q};
	assign m_axis_tuser  = m_status_q;

`ifndef ASSERT_OFF
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= fbpa_pkg::DEPTH_W'(fbpa_pkg::MAX_BLOCKS))
		else $error("free stack depth above pool size");

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= fbpa_pkg::DEPTH_W'(fbpa_pkg::MAX_BLOCKS))
		else $error("fresh index above pool size");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (depth_q != '0 && !ram_we))
		else $error("pop from empty stack or overlapping push");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider restarted while busy");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (m_axis_tvalid && m_axis_tuser == $past(res_status_q)))
		else $error("result word not presented after load");
`endif

endmodule

`default_nettype wire
